FILE: rtl/sst_pkg.sv
// shared constants, payload types and a helper for the sorted string table search
package sst_pkg;

    localparam int ENTRIES  = 256;
    localparam int MAX_LEN  = 32;
    localparam int ENTRY_W  = $clog2(ENTRIES);
    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int CNT_W    = ENTRY_W + 1;
    localparam int CPOS_W   = POS_W + 1;
    localparam int ADDR_W   = ENTRY_W + POS_W;
    localparam int CHAR_W   = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [7:0]        entry;
        logic [4:0]        position;
        logic [CHAR_W-1:0] char_code;
    } sst_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] index;
    } sst_result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } sst_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } sst_rd_t;

    // ascii upper case folded to lower case, everything else untouched
    function automatic logic [CHAR_W-1:0] sst_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_W'(16'h0041) && c <= CHAR_W'(16'h005A))
        begin
            r = c + CHAR_W'(16'h0020);
        end
        return r;
    endfunction

endpackage

FILE: rtl/sst_table_ram.sv
// table character memory, one write port and one registered read port
module sst_table_ram (
    input  logic                            clk,
    input  sst_pkg::sst_wr_t                wr,
    input  sst_pkg::sst_rd_t                rd,
    output logic [sst_pkg::CHAR_W-1:0]      rd_data
);

    logic [sst_pkg::CHAR_W-1:0] mem [sst_pkg::ENTRIES*sst_pkg::MAX_LEN];
    logic [sst_pkg::CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sst_search_ctrl.sv
// query sequencer: range narrowing by binary searches over the table memory
module sst_search_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic [sst_pkg::CHAR_W-1:0]      q_char,
    input  logic [sst_pkg::CNT_W-1:0]       entry_count,
    input  logic [sst_pkg::CHAR_W-1:0]      rd_data,
    output sst_pkg::sst_rd_t                rd,
    output logic                            busy,
    output logic                            done,
    output sst_pkg::sst_result_t            result
);

    typedef enum logic [1:0] {ST_IDLE, ST_PROBE, ST_CHECK} state_t;
    typedef enum logic [1:0] {MODE_READY, MODE_NARROW, MODE_SINGLE, MODE_FAILED} mode_t;
    typedef enum logic [1:0] {PH_MAIN, PH_LEFT, PH_RIGHT, PH_SINGLE} phase_t;

    localparam int CW = sst_pkg::CNT_W;
    localparam int PW = sst_pkg::CPOS_W;

    state_t                     state_reg, state_next;
    mode_t                      mode_reg, mode_next;
    phase_t                     phase_reg, phase_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [CW-1:0]              lend_reg, lend_next;
    logic [CW-1:0]              up_reg, up_next;
    logic [CW-1:0]              probe_reg, probe_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic [sst_pkg::CHAR_W-1:0] ch_reg, ch_next;
    logic                       done_reg, done_next;
    logic                       found_reg, found_next;
    logic [7:0]                 index_reg, index_next;

    logic [sst_pkg::CHAR_W-1:0] ch_in;
    logic [CW-1:0]              clamp_cnt;
    mode_t                      eff_mode;
    logic [CW-1:0]              eff_lo, eff_hi;
    logic [PW-1:0]              eff_pos;
    logic [CW-1:0]              span, base, probe;
    logic [PW-1:0]              pos_adv;
    logic [sst_pkg::CHAR_W-1:0] a_low;

    assign ch_in     = sst_pkg::sst_lower(q_char);
    assign clamp_cnt = (entry_count > CW'(sst_pkg::ENTRIES)) ? CW'(sst_pkg::ENTRIES)
                                                              : entry_count;

    // a fresh query starts from the whole table
    assign eff_mode = (mode_reg == MODE_READY) ? MODE_NARROW : mode_reg;
    assign eff_lo   = (mode_reg == MODE_READY) ? '0 : lo_reg;
    assign eff_hi   = (mode_reg == MODE_READY) ? clamp_cnt : hi_reg;
    assign eff_pos  = (mode_reg == MODE_READY) ? '0 : pos_reg;

    assign span  = (phase_reg == PH_LEFT)  ? (lend_reg - lo_reg) :
                   (phase_reg == PH_RIGHT) ? (hi_reg - up_reg) : (hi_reg - lo_reg);
    assign base  = (phase_reg == PH_RIGHT) ? up_reg : lo_reg;
    assign probe = (phase_reg == PH_SINGLE) ? lo_reg : (base + (span >> 1));

    assign pos_adv = (pos_reg == PW'(sst_pkg::MAX_LEN)) ? pos_reg : (pos_reg + PW'(1));

    // positions past the table width read as zero
    assign a_low = pos_reg[PW-1] ? '0 : sst_pkg::sst_lower(rd_data);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        lend_next  = lend_reg;
        up_next    = up_reg;
        probe_next = probe_reg;
        pos_next   = pos_reg;
        ch_next    = ch_reg;
        done_next  = 1'b0;
        found_next = 1'b0;
        index_next = '0;
        rd.en      = 1'b0;
        rd.addr    = {probe[sst_pkg::ENTRY_W-1:0], pos_reg[sst_pkg::POS_W-1:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    ch_next  = ch_in;
                    lo_next  = eff_lo;
                    hi_next  = eff_hi;
                    pos_next = eff_pos;
                    if (eff_mode == MODE_SINGLE ||
                        (eff_mode == MODE_NARROW && eff_lo != eff_hi))
                    begin
                        state_next = ST_PROBE;
                        if (eff_mode == MODE_SINGLE || eff_lo + CW'(1) == eff_hi)
                        begin
                            mode_next  = MODE_SINGLE;
                            phase_next = PH_SINGLE;
                        end
                        else if (ch_in == '0)
                        begin
                            // terminator with several entries left: check the first
                            mode_next  = MODE_NARROW;
                            phase_next = PH_SINGLE;
                        end
                        else
                        begin
                            mode_next  = MODE_NARROW;
                            phase_next = PH_MAIN;
                        end
                    end
                    else if (ch_in == '0)
                    begin
                        done_next = 1'b1;
                        mode_next = MODE_READY;
                    end
                    else
                    begin
                        mode_next = MODE_FAILED;
                    end
                end
            end

            ST_PROBE:
            begin
                if ((phase_reg == PH_MAIN && lo_reg == hi_reg) ||
                    (phase_reg == PH_RIGHT && up_reg == hi_reg))
                begin
                    state_next = ST_IDLE;
                    if (lo_reg == hi_reg)
                    begin
                        mode_next = MODE_FAILED;
                    end
                    else
                    begin
                        mode_next = MODE_NARROW;
                        pos_next  = pos_adv;
                    end
                end
                else if (phase_reg == PH_LEFT && lo_reg == lend_reg)
                begin
                    phase_next = PH_RIGHT;
                end
                else
                begin
                    rd.en      = 1'b1;
                    probe_next = probe;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                state_next = ST_PROBE;
                case (phase_reg)
                    PH_MAIN:
                    begin
                        if (a_low < ch_reg)
                        begin
                            lo_next = probe_reg + CW'(1);
                        end
                        else if (a_low > ch_reg)
                        begin
                            hi_next = probe_reg;
                        end
                        else
                        begin
                            lend_next  = probe_reg;
                            up_next    = probe_reg + CW'(1);
                            phase_next = PH_LEFT;
                        end
                    end
                    PH_LEFT:
                    begin
                        if (a_low < ch_reg)
                        begin
                            lo_next = probe_reg + CW'(1);
                        end
                        else
                        begin
                            lend_next = probe_reg;
                        end
                    end
                    PH_RIGHT:
                    begin
                        if (ch_reg >= a_low)
                        begin
                            up_next = probe_reg + CW'(1);
                        end
                        else
                        begin
                            hi_next = probe_reg;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                        if (ch_reg == '0)
                        begin
                            done_next  = 1'b1;
                            found_next = (a_low == '0);
                            index_next = (a_low == '0) ? lo_reg[7:0] : '0;
                            mode_next  = MODE_READY;
                        end
                        else if (a_low != ch_reg)
                        begin
                            mode_next = MODE_FAILED;
                        end
                        else
                        begin
                            pos_next = pos_adv;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_READY;
            phase_reg <= PH_MAIN;
            lo_reg    <= '0;
            hi_reg    <= '0;
            lend_reg  <= '0;
            up_reg    <= '0;
            probe_reg <= '0;
            pos_reg   <= '0;
            ch_reg    <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            index_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            lend_reg  <= lend_next;
            up_reg    <= up_next;
            probe_reg <= probe_next;
            pos_reg   <= pos_next;
            ch_reg    <= ch_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            index_reg <= index_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign result.found = found_reg;
    assign result.index = index_reg;

endmodule

FILE: rtl/sorted_string_table_search.sv
// top level: configuration register, load path, table memory and query sequencer
//
// Case-insensitive lookup in a sorted table of 256 entries of up to 32 characters.
// A load item (op 0) writes one character and never makes the block busy. A query
// item (op 1) carries one character; a zero character ends the query, and the result
// sits on result for exactly one cycle with done high: the cycle after acceptance
// when the query had already failed, otherwise the cycle in which busy falls after
// the last probe. The receiver cannot hold it off, so it must sample it then.
// A query character that needs no table read is taken without going busy. Otherwise the
// sequencer uses the single read port of the table memory: each probe issues the
// address, then compares the registered read data, and narrowing one character runs a
// binary search for a match plus a lower and an upper bound search, in all at most
// 2*log2(entries) probes. Once one entry is left, each character costs one probe.
// busy is high while this runs.
// The table is not cleared by reset: entries must be loaded before they are used,
// and entry_count is taken at the start of each query.
module sorted_string_table_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  sst_pkg::sst_item_t          cmd,
    output logic                        busy,
    output logic                        done,
    output sst_pkg::sst_result_t        result,
    input  logic                        cfg_we,
    input  logic [sst_pkg::CNT_W-1:0]   cfg_wdata
);

    logic [sst_pkg::CNT_W-1:0]  entry_count_reg;
    logic                       accept;
    sst_pkg::sst_wr_t           wr;
    sst_pkg::sst_rd_t           rd;
    logic [sst_pkg::CHAR_W-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    assign accept  = start && !busy;
    assign wr.en   = accept && (cmd.op == sst_pkg::OP_LOAD);
    assign wr.addr = {cmd.entry[sst_pkg::ENTRY_W-1:0], cmd.position[sst_pkg::POS_W-1:0]};
    assign wr.data = cmd.char_code;

    sst_table_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    sst_search_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (accept && (cmd.op == sst_pkg::OP_QUERY)),
        .q_char      (cmd.char_code),
        .entry_count (entry_count_reg),
        .rd_data     (rd_data),
        .rd          (rd),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    // a load item never starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == sst_pkg::OP_LOAD) |=> !busy)
        else $error("load item made the block busy");

    // a result only follows a query item or sequencer work
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || (start && cmd.op == sst_pkg::OP_QUERY)))
        else $error("result without a query");

    // a miss always reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.index == '0))
        else $error("not-found result with nonzero index");

    // the sequencer never reads the table while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        rd.en |-> busy)
        else $error("table read outside a query");

endmodule

FILE: tb/sv/tb_sorted_string_table_search.sv
`timescale 1ns / 100ps
// testbench for the sorted string table search: table loads, case-blind queries, result checks
module tb_sorted_string_table_search;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 80;
    localparam int QBUF_LEN    = 40;

    typedef logic [sst_pkg::MAX_LEN*sst_pkg::CHAR_W-1:0] text_t;
    typedef enum logic [1:0] {SM_READY, SM_NARROW, SM_SINGLE, SM_FAILED} search_mode_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    sst_pkg::sst_item_t         cmd;
    logic                       busy;
    logic                       done;
    sst_pkg::sst_result_t       result;
    logic                       cfg_we;
    logic [sst_pkg::CNT_W-1:0]  cfg_wdata;

    // predictor state
    logic [sst_pkg::CHAR_W-1:0] tbl_copy [0:sst_pkg::ENTRIES-1][0:sst_pkg::MAX_LEN-1];
    logic [sst_pkg::CNT_W-1:0]  count_reg;
    logic [sst_pkg::CNT_W-1:0]  range_lo;
    logic [sst_pkg::CNT_W-1:0]  range_hi;
    logic [sst_pkg::CPOS_W-1:0] char_pos;
    search_mode_t               mode;
    sst_pkg::sst_result_t       results_due [$];
    sst_pkg::sst_result_t       want;

    // stimulus state
    text_t                      keys [0:sst_pkg::ENTRIES-1];
    int                         n_keys = 0;
    logic [sst_pkg::CHAR_W-1:0] qbuf [0:QBUF_LEN-1];
    int                         qlen = 0;
    bit                         gaps_on = 1'b1;
    int                         query_items = 0;
    int                         err_count = 0;
    int                         cycle_count = 0;

    always #5 clk = ~clk;

    sorted_string_table_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    function automatic logic [sst_pkg::CHAR_W-1:0] fold_case(
        input logic [sst_pkg::CHAR_W-1:0] c);
        if (c >= 16'h0041 && c <= 16'h005A)
            return c + 16'h0020;
        return c;
    endfunction

    // positions past the table width read as zero
    function automatic logic [sst_pkg::CHAR_W-1:0] folded_at(input int e, input int p);
        if (e >= sst_pkg::ENTRIES || p >= sst_pkg::MAX_LEN)
            return '0;
        return fold_case(tbl_copy[e][p]);
    endfunction

    // cut the kept range down to the entries whose folded char at char_pos equals ch
    function automatic void narrow_range(input logic [sst_pkg::CHAR_W-1:0] ch);
        int                         lo;
        int                         hi;
        int                         p;
        int                         mid;
        int                         lend;
        int                         up;
        int                         m;
        bit                         hit;
        logic [sst_pkg::CHAR_W-1:0] a;
        lo  = int'(range_lo);
        hi  = int'(range_hi);
        p   = int'(char_pos);
        hit = 1'b0;
        while (lo != hi && !hit)
        begin
            mid = lo + (hi - lo) / 2;
            a   = folded_at(mid, p);
            if (a < ch)
                lo = mid + 1;
            else if (a > ch)
                hi = mid;
            else
            begin
                hit  = 1'b1;
                lend = mid;
                up   = mid + 1;
                while (lo != lend)
                begin
                    m = lo + (lend - lo) / 2;
                    if (folded_at(m, p) < ch)
                        lo = m + 1;
                    else
                        lend = m;
                end
                while (up != hi)
                begin
                    m = up + (hi - up) / 2;
                    if (ch >= folded_at(m, p))
                        up = m + 1;
                    else
                        hi = m;
                end
            end
        end
        range_lo = sst_pkg::CNT_W'(lo);
        range_hi = sst_pkg::CNT_W'(hi);
    endfunction

    function automatic void post_result(input bit hit,
                                        input logic [sst_pkg::CNT_W-1:0] idx);
        sst_pkg::sst_result_t r;
        r.found = hit;
        r.index = hit ? idx[7:0] : 8'h00;
        results_due.push_back(r);
        mode = SM_READY;
    endfunction

    function automatic void step_char_pos();
        if (char_pos < sst_pkg::CPOS_W'(sst_pkg::MAX_LEN))
            char_pos = char_pos + 1'b1;
    endfunction

    function automatic void predict_search(input sst_pkg::sst_item_t it);
        logic [sst_pkg::CHAR_W-1:0] ch;
        logic [sst_pkg::CHAR_W-1:0] a;
        ch = fold_case(it.char_code);
        if (it.op == sst_pkg::OP_LOAD)
        begin
            tbl_copy[it.entry][it.position] = it.char_code;
            return;
        end
        if (mode == SM_READY)
        begin
            range_lo = '0;
            range_hi = (count_reg > sst_pkg::CNT_W'(sst_pkg::ENTRIES))
                       ? sst_pkg::CNT_W'(sst_pkg::ENTRIES) : count_reg;
            char_pos = '0;
            mode     = SM_NARROW;
        end
        if (mode == SM_NARROW)
        begin
            if (range_lo == range_hi)
                mode = SM_FAILED;
            else if (range_lo + 1'b1 == range_hi)
                mode = SM_SINGLE;
            else if (ch == '0)
            begin
                post_result(folded_at(int'(range_lo), int'(char_pos)) == '0, range_lo);
                return;
            end
            else
            begin
                narrow_range(ch);
                if (range_lo == range_hi)
                    mode = SM_FAILED;
                else
                    step_char_pos();
                return;
            end
        end
        if (mode == SM_SINGLE)
        begin
            a = folded_at(int'(range_lo), int'(char_pos));
            if (ch == '0)
            begin
                post_result(a == '0, range_lo);
                return;
            end
            if (a != ch)
                mode = SM_FAILED;
            else
                step_char_pos();
            return;
        end
        if (ch == '0)
            post_result(1'b0, '0);
    endfunction

    function automatic void report_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
                report_error($sformatf("unexpected result: found=%0b index=%0d",
                                       result.found, result.index));
            else
            begin
                want = results_due.pop_front();
                if (result.found !== want.found || result.index !== want.index)
                    report_error($sformatf(
                        "result mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                        want.found, want.index, result.found, result.index));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one item, held until the block takes it
    task automatic send_item(input sst_pkg::sst_item_t it);
        if (gaps_on && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 27);
        end
        start <= 1'b1;
        cmd   <= it;
        do @(posedge clk); while (busy);
        predict_search(it);
        if (it.op == sst_pkg::OP_QUERY)
            query_items++;
    endtask

    task automatic load_char(input int e, input int p, input logic [sst_pkg::CHAR_W-1:0] c);
        sst_pkg::sst_item_t it;
        it.op        = sst_pkg::OP_LOAD;
        it.entry     = 8'(e);
        it.position  = 5'(p);
        it.char_code = c;
        send_item(it);
    endtask

    task automatic query_char(input logic [sst_pkg::CHAR_W-1:0] c);
        sst_pkg::sst_item_t it;
        it.op        = sst_pkg::OP_QUERY;
        it.entry     = 8'($urandom);
        it.position  = 5'($urandom);
        it.char_code = c;
        send_item(it);
    endtask

    // wait for every expected result, then let the block go quiet
    task automatic drain();
        start <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [sst_pkg::CNT_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        count_reg = v;
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [sst_pkg::CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 16'h0061;
        if (r < 55) return 16'h0062;
        if (r < 75) return 16'h0063;
        if (r < 80) return 16'h007A;
        if (r < 84) return 16'h0040;
        if (r < 88) return 16'h005B;
        if (r < 92) return 16'h00C0;
        if (r < 96) return 16'h8001;
        return 16'hFFFF;
    endfunction

    function automatic logic [sst_pkg::CHAR_W-1:0] mix_case(
        input logic [sst_pkg::CHAR_W-1:0] c, input bit force_up);
        if (c >= 16'h0061 && c <= 16'h007A && (force_up || $urandom_range(1) == 1))
            return c - 16'h0020;
        return c;
    endfunction

    function automatic logic [sst_pkg::CHAR_W-1:0] text_char(input text_t t, input int i);
        if (i >= sst_pkg::MAX_LEN)
            return '0;
        return t[(sst_pkg::MAX_LEN-1-i)*sst_pkg::CHAR_W +: sst_pkg::CHAR_W];
    endfunction

    function automatic int text_len(input text_t t);
        int n;
        n = 0;
        while (n < sst_pkg::MAX_LEN && text_char(t, n) != '0)
            n++;
        return n;
    endfunction

    function automatic text_t random_text();
        text_t t;
        int    len;
        int    r;
        r = $urandom_range(99);
        if (r < 4)
            len = 0;
        else if (r < 8)
            len = sst_pkg::MAX_LEN;
        else
            len = $urandom_range(1, 6);
        t = '0;
        for (int i = 0; i < len; i++)
            t[(sst_pkg::MAX_LEN-1-i)*sst_pkg::CHAR_W +: sst_pkg::CHAR_W] = pick_char();
        return t;
    endfunction

    // sorted by folded text, loaded in mixed case over every position of entries 0..n-1
    task automatic build_table(input int n);
        text_t k;
        int    j;
        for (int i = 0; i < n; i++)
            keys[i] = random_text();
        if (n == sst_pkg::ENTRIES)
        begin
            keys[0] = '0;
            keys[1] = '1;
        end
        for (int i = 1; i < n; i++)
        begin
            k = keys[i];
            j = i - 1;
            while (j >= 0 && keys[j] > k)
            begin
                keys[j+1] = keys[j];
                j--;
            end
            keys[j+1] = k;
        end
        for (int e = 0; e < n; e++)
            for (int p = 0; p < sst_pkg::MAX_LEN; p++)
                load_char(e, p, mix_case(text_char(keys[e], p), 1'b0));
        n_keys = n;
    endtask

    task automatic copy_key(input int e, input int len, input bit force_up);
        for (int i = 0; i < len; i++)
            qbuf[i] = mix_case(text_char(keys[e], i), force_up);
        qlen = len;
    endtask

    // query text then terminator, with the odd table write slipped in mid query
    task automatic run_query();
        for (int i = 0; i < qlen; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                if ($urandom_range(1) == 1)
                    load_char($urandom_range(sst_pkg::ENTRIES-1),
                              $urandom_range(sst_pkg::MAX_LEN-1),
                              mix_case(pick_char(), 1'b0));
                else
                    load_char($urandom_range(sst_pkg::ENTRIES-1),
                              $urandom_range(sst_pkg::MAX_LEN-1),
                              16'($urandom));
            end
            query_char(qbuf[i]);
        end
        query_char(16'h0000);
    endtask

    task automatic random_query();
        int e;
        int len;
        int v;
        if (n_keys > 0 && $urandom_range(99) < 75)
        begin
            e   = $urandom_range(n_keys-1);
            len = text_len(keys[e]);
            copy_key(e, len, 1'b0);
            v = $urandom_range(99);
            if (v < 15 && len > 0)
                qlen = $urandom_range(len-1);
            else if (v < 30)
            begin
                // extra characters, past the table width for full-length entries
                repeat ($urandom_range(1, 3))
                begin
                    qbuf[qlen] = mix_case(pick_char(), 1'b0);
                    qlen++;
                end
            end
            else if (v < 40 && len > 0)
                qbuf[$urandom_range(len-1)] = pick_char();
        end
        else
        begin
            qlen = $urandom_range(5);
            for (int i = 0; i < qlen; i++)
                qbuf[i] = ($urandom_range(1) == 1) ? mix_case(pick_char(), 1'b0)
                                                   : 16'($urandom);
        end
        run_query();
    endtask

    task automatic test_directed();
        write_count(sst_pkg::CNT_W'(sst_pkg::ENTRIES));
        build_table(sst_pkg::ENTRIES);
        // empty query hits the empty first entry
        qlen = 0;
        run_query();
        copy_key(128, text_len(keys[128]), 1'b1);
        run_query();
        // only the start of the full-length top entry
        copy_key(255, 3, 1'b0);
        run_query();
        // below every nonempty entry in the table, range goes empty
        qbuf[0] = 16'h0001;
        qlen    = 1;
        run_query();
        copy_key(60, text_len(keys[60]), 1'b0);
        if (qlen > 0)
            qbuf[qlen-1] = 16'hFFFE;
        else
        begin
            qbuf[0] = 16'h0062;
            qlen    = 1;
        end
        run_query();
    endtask

    task automatic test_count_extremes();
        write_count('0);
        qbuf[0] = 16'h0061;
        qlen    = 1;
        run_query();
        qlen = 0;
        run_query();
        // single entry left from the start
        write_count(sst_pkg::CNT_W'(1));
        qlen = 0;
        run_query();
        qbuf[0] = 16'h0062;
        qlen    = 1;
        run_query();
        // count beyond the table is clamped
        write_count('1);
        copy_key(200, text_len(keys[200]), 1'b0);
        run_query();
    endtask

    task automatic test_random_search(input logic [sst_pkg::CNT_W-1:0] count,
                                      input int item_goal,
                                      input bit reload, input bit idle);
        int goal_end;
        gaps_on = idle;
        write_count(count);
        if (reload && count != '0)
            build_table((count > sst_pkg::CNT_W'(sst_pkg::ENTRIES)) ? sst_pkg::ENTRIES
                                                                     : int'(count));
        goal_end = query_items + item_goal;
        while (query_items < goal_end)
            random_query();
        drain();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        count_reg = '0;
        range_lo  = '0;
        range_hi  = '0;
        char_pos  = '0;
        mode      = SM_READY;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_count_extremes();
        test_random_search(sst_pkg::CNT_W'(sst_pkg::ENTRIES), 400, 1'b0, 1'b1);
        test_random_search(sst_pkg::CNT_W'(300), 300, 1'b0, 1'b0);
        test_random_search(sst_pkg::CNT_W'(1), 100, 1'b1, 1'b1);
        test_random_search(sst_pkg::CNT_W'(2), 100, 1'b1, 1'b1);
        test_random_search(sst_pkg::CNT_W'($urandom_range(3, 40)), 300, 1'b1, 1'b1);
        test_random_search('0, 50, 1'b0, 1'b1);
        test_random_search('1, 350, 1'b1, 1'b1);
        test_random_search(sst_pkg::CNT_W'($urandom_range(100, 255)), 400, 1'b0, 1'b1);

        drain();
        if (err_count == 0 && results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
